/* sv/assert_macros.svh */
// Assertion helpers used by qfp_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define QFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define QFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("assertion failed");
`endif

/* sv/qfp_pkg.sv */
//------------------------------------------------------------------------------
// qfp_pkg
// Types and constants of the QUIC frame parser.
//------------------------------------------------------------------------------
`default_nettype none
package qfp_pkg;
    localparam logic [61:0] VMAX  = {62{1'b1}};
    localparam logic [61:0] LIM60 = 62'h1000_0000_0000_0000;

    localparam int QDEPTH_DEF = 2;

    localparam logic [1:0] K_FIELD = 2'd0;
    localparam logic [1:0] K_BYTE  = 2'd1;
    localparam logic [1:0] K_DONE  = 2'd2;
    localparam logic [1:0] K_ERR   = 2'd3;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_FRAME = 2'd1;
    localparam logic [1:0] E_LIMIT = 2'd2;

    localparam logic [0:0] CFG_MIN_CID = 1'b0;
    localparam logic [0:0] CFG_MAX_CID = 1'b1;

    localparam logic [2:0] FL_OFF = 3'h4;
    localparam logic [2:0] FL_LEN = 3'h2;
    localparam logic [2:0] FL_FIN = 3'h1;
    localparam logic [4:0] T_STREAM = 5'd8;
    localparam logic [4:0] T_CLOSE  = 5'd28;
    localparam logic [4:0] T_NEWCID = 5'd24;

    typedef enum logic [2:0] {
        PH_TYPE, PH_VAR, PH_BYTES, PH_TOEND, PH_CIDLEN
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       packet_end;
    } t_in;

    typedef struct packed {
        logic [4:0]  frame_type;
        logic [2:0]  type_flags;
        logic [1:0]  item_kind;
        logic [3:0]  field_index;
        logic [61:0] field_value;
        logic        frame_done;
        logic [1:0]  error_code;
    } t_out;

    // Front-end classification handed to the parser.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       packet_end;
        logic       first;      // byte starts a varint
        logic [2:0] vlen_m1;    // extra bytes announced by a first byte
    } t_cls;
endpackage
`default_nettype wire

/* sv/qfp_front.sv */
//------------------------------------------------------------------------------
// qfp_front
// Input stage with a small queue: tags each byte with varint length info.
//------------------------------------------------------------------------------
`default_nettype none
module qfp_front #(
    parameter int QDEPTH = qfp_pkg::QDEPTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  qfp_pkg::t_in   i_data,
    input  wire            i_first,
    output logic           o_valid,
    input  wire            i_ready,
    output qfp_pkg::t_cls  o_data
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    qfp_pkg::t_cls r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    qfp_pkg::t_cls w_cls;
    logic          w_push, w_pop;

    always_comb begin
        w_cls.in_byte    = i_data.in_byte;
        w_cls.packet_end = i_data.packet_end;
        w_cls.first      = i_first;
        case (i_data.in_byte[7:6])
            2'd0:    w_cls.vlen_m1 = 3'd0;
            2'd1:    w_cls.vlen_m1 = 3'd1;
            2'd2:    w_cls.vlen_m1 = 3'd3;
            default: w_cls.vlen_m1 = 3'd7;
        endcase
    end

    assign o_ready = (r_cnt != (AW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

/* sv/qfp_back.sv */
//------------------------------------------------------------------------------
// qfp_back
// Frame parser state machine with a registered result stage.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module qfp_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  qfp_pkg::t_cls  i_data,
    input  wire  [7:0]     i_min_cid,
    input  wire  [7:0]     i_max_cid,
    output logic           o_valid,
    input  wire            i_ready,
    output qfp_pkg::t_out  o_data
);
    qfp_pkg::t_phase r_ph, n_ph;
    logic [61:0] r_acc, n_acc;
    logic [2:0]  r_left, n_left;
    logic [3:0]  r_pos, n_pos;
    logic [4:0]  r_typ, n_typ;
    logic [2:0]  r_flg, n_flg;
    logic [61:0] r_pay, n_pay;
    logic [62:0] r_rng, n_rng;
    logic [61:0] r_sav, n_sav;
    logic        r_disc, n_disc;
    logic        r_ov, n_ov;
    qfp_pkg::t_out r_out, n_out;

    logic        w_go, w_emit;
    logic [61:0] w_v;
    logic        w_vdone;
    logic [62:0] w_sum;
    logic        pe;
    logic [7:0]  b;

    assign o_ready = !r_ov || i_ready;
    assign w_go    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign pe = i_data.packet_end;
    assign b  = i_data.in_byte;

    // next state
    always_comb begin
        logic [3:0] p;
        logic       fdone, ferr, fl;
        logic [1:0] fcode;
        logic [3:0] np;
        logic [2:0] act; // 0 var,1 bytes,2 done,3 toend,4 cidlen
        n_ph = r_ph; n_acc = r_acc; n_left = r_left; n_pos = r_pos;
        n_typ = r_typ; n_flg = r_flg; n_pay = r_pay; n_rng = r_rng;
        n_sav = r_sav; n_disc = r_disc;
        n_out = r_out; w_emit = 1'b0;
        w_v = '0; w_vdone = 1'b0; w_sum = '0;
        p = r_pos; fdone = 1'b0; ferr = 1'b0; fcode = qfp_pkg::E_FRAME;
        np = '0; act = 3'd2; fl = 1'b0;
        if (r_disc) begin
            if (pe) begin
                n_disc = 1'b0; n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0;
            end
        end else begin
            case (r_ph)
                qfp_pkg::PH_TYPE, qfp_pkg::PH_VAR: begin
                    if (r_left == '0) begin
                        if (r_ph == qfp_pkg::PH_TYPE) begin
                            n_typ = '0; n_flg = '0; n_pos = '0;
                        end
                        w_v = {56'd0, b[5:0]};
                        n_left = i_data.vlen_m1;
                    end else begin
                        w_v = {r_acc[53:0], b};
                        n_left = r_left - 3'd1;
                    end
                    n_acc = w_v;
                    w_vdone = (n_left == '0);
                    if (w_vdone && r_ph == qfp_pkg::PH_TYPE) begin
                        if (w_v > 62'd30) begin
                            ferr = 1'b1;
                            n_out = '{n_typ, n_flg, qfp_pkg::K_ERR, n_pos, w_v, 1'b0,
                                      qfp_pkg::E_FRAME};
                            w_emit = 1'b1;
                            n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0; n_disc = 1'b1;
                        end else begin
                            n_typ = w_v[4:0]; n_flg = '0; n_pos = '0;
                            if (w_v == 62'd0 || w_v == 62'd1 || w_v == 62'd30) begin
                                n_out = '{n_typ, 3'd0, qfp_pkg::K_DONE, 4'd0, 62'd0, 1'b1,
                                          qfp_pkg::E_NONE};
                                w_emit = 1'b1;
                                n_ph = qfp_pkg::PH_TYPE; n_left = '0;
                            end else begin
                                if (w_v[4:3] == 2'b01) begin
                                    n_typ = qfp_pkg::T_STREAM; n_flg = w_v[2:0];
                                end else if (w_v[4:1] == 4'b1110) begin
                                    n_typ = qfp_pkg::T_CLOSE; n_flg = {2'b0, w_v[0]};
                                end
                                if (w_v[4:1] == 4'b1101) begin
                                    n_ph = qfp_pkg::PH_BYTES; n_pay = 62'd8;
                                end else begin
                                    n_ph = qfp_pkg::PH_VAR;
                                end
                            end
                        end
                    end else if (w_vdone) begin
                        w_sum = {1'b0, r_sav} + {1'b0, w_v};
                        case (r_typ)
                            5'd2, 5'd3: begin
                                if (p == 4'd0) begin act = 3'd0; np = 4'd1; end
                                else if (p == 4'd1) begin act = 3'd0; np = 4'd2; end
                                else if (p == 4'd2) begin
                                    n_rng = {w_v, 1'b1}; act = 3'd0; np = 4'd3;
                                end else if (p <= 4'd5) begin
                                    n_rng = r_rng - 63'd1;
                                    if (n_rng == '0) begin
                                        if (r_typ == 5'd3) begin act = 3'd0; np = 4'd6; end
                                    end else begin
                                        act = 3'd0; np = (p == 4'd4) ? 4'd5 : 4'd4;
                                    end
                                end else if (p < 4'd8) begin act = 3'd0; np = p + 4'd1; end
                            end
                            5'd4: if (p < 4'd2) begin act = 3'd0; np = p + 4'd1; end
                            5'd5, 5'd17, 5'd21: if (p < 4'd1) begin act = 3'd0; np = 4'd1; end
                            5'd6: begin
                                if (p == 4'd0) begin n_sav = w_v; act = 3'd0; np = 4'd1; end
                                else if (w_sum[62]) ferr = 1'b1;
                                else if (w_v != '0) begin
                                    act = 3'd1; np = 4'd2; n_pay = w_v;
                                end
                            end
                            5'd7: begin
                                if (w_v == '0) ferr = 1'b1;
                                else begin act = 3'd1; np = 4'd1; n_pay = w_v; end
                            end
                            qfp_pkg::T_STREAM: begin
                                if (p == 4'd0 && (r_flg & qfp_pkg::FL_OFF) != 0) begin
                                    act = 3'd0; np = 4'd1;
                                end else if (p < 4'd2 && (r_flg & qfp_pkg::FL_LEN) != 0) begin
                                    act = 3'd0; np = 4'd2;
                                end else if (p < 4'd2) begin
                                    act = pe ? 3'd2 : 3'd3; np = 4'd3;
                                end else if (w_v != '0) begin
                                    act = 3'd1; np = 4'd3; n_pay = w_v;
                                end
                            end
                            5'd18, 5'd19: if (w_v > qfp_pkg::LIM60) ferr = 1'b1;
                            5'd22, 5'd23: if (w_v > qfp_pkg::LIM60) begin
                                ferr = 1'b1; fcode = qfp_pkg::E_LIMIT;
                            end
                            qfp_pkg::T_NEWCID: begin
                                if (p == 4'd0) begin n_sav = w_v; act = 3'd0; np = 4'd1; end
                                else if (w_v > r_sav) ferr = 1'b1;
                                else begin act = 3'd4; np = 4'd2; end
                            end
                            qfp_pkg::T_CLOSE: begin
                                if (p == 4'd0) begin
                                    act = 3'd0; np = r_flg[0] ? 4'd2 : 4'd1;
                                end else if (p == 4'd1) begin act = 3'd0; np = 4'd2; end
                                else if (w_v != '0) begin
                                    act = 3'd1; np = 4'd3; n_pay = w_v;
                                end
                            end
                            default: ;
                        endcase
                        w_emit = 1'b1;
                        if (ferr) begin
                            n_out = '{r_typ, r_flg, qfp_pkg::K_ERR, p, 62'd0, 1'b0, fcode};
                            n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0; n_disc = 1'b1;
                        end else begin
                            fdone = (act == 3'd2);
                            n_out = '{r_typ, r_flg, qfp_pkg::K_FIELD, p, w_v, fdone,
                                      qfp_pkg::E_NONE};
                            if (fdone) begin
                                n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0;
                            end else begin
                                n_pos = np; n_left = '0;
                                case (act)
                                    3'd0: n_ph = qfp_pkg::PH_VAR;
                                    3'd1: n_ph = qfp_pkg::PH_BYTES;
                                    3'd3: n_ph = qfp_pkg::PH_TOEND;
                                    default: n_ph = qfp_pkg::PH_CIDLEN;
                                endcase
                            end
                        end
                    end
                end
                qfp_pkg::PH_BYTES: begin
                    n_pay = r_pay - 62'd1;
                    w_emit = 1'b1;
                    fl = (n_pay == '0);
                    if (fl && r_typ == qfp_pkg::T_NEWCID && r_pos == 4'd3) begin
                        n_out = '{r_typ, r_flg, qfp_pkg::K_BYTE, r_pos, {54'd0, b}, 1'b0,
                                  qfp_pkg::E_NONE};
                        n_pos = 4'd4; n_pay = 62'd16;
                    end else begin
                        n_out = '{r_typ, r_flg, qfp_pkg::K_BYTE, r_pos, {54'd0, b}, fl,
                                  qfp_pkg::E_NONE};
                        if (fl) begin
                            n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0;
                        end
                    end
                end
                qfp_pkg::PH_TOEND: begin
                    w_emit = 1'b1;
                    n_out = '{r_typ, r_flg, qfp_pkg::K_BYTE, r_pos, {54'd0, b}, pe,
                              qfp_pkg::E_NONE};
                    if (pe) begin n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0; end
                end
                default: begin
                    w_emit = 1'b1;
                    if (b < i_min_cid || b > i_max_cid) begin
                        n_out = '{r_typ, r_flg, qfp_pkg::K_ERR, r_pos, 62'd0, 1'b0,
                                  qfp_pkg::E_FRAME};
                        n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0; n_disc = 1'b1;
                    end else begin
                        n_out = '{r_typ, r_flg, qfp_pkg::K_FIELD, 4'd2, {54'd0, b}, 1'b0,
                                  qfp_pkg::E_NONE};
                        n_ph = qfp_pkg::PH_BYTES;
                        if (b == 8'd0) begin n_pos = 4'd4; n_pay = 62'd16; end
                        else begin n_pos = 4'd3; n_pay = {54'd0, b}; end
                    end
                end
            endcase
            if (pe) begin
                if (!(w_emit && n_out.item_kind == qfp_pkg::K_ERR) &&
                    !(n_ph == qfp_pkg::PH_TYPE && n_left == '0)) begin
                    n_out = '{n_typ, n_flg, qfp_pkg::K_ERR, n_pos, 62'd0, 1'b0,
                              qfp_pkg::E_FRAME};
                    w_emit = 1'b1;
                end
                n_disc = 1'b0; n_ph = qfp_pkg::PH_TYPE; n_left = '0; n_pos = '0;
            end
        end
    end

    // output valid
    always_comb begin
        n_ov = r_ov;
        if (i_ready) n_ov = 1'b0;
        if (w_go && w_emit) n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= qfp_pkg::PH_TYPE; r_acc <= '0; r_left <= '0; r_pos <= '0;
            r_typ <= '0; r_flg <= '0; r_pay <= '0; r_rng <= '0; r_sav <= '0;
            r_disc <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
            if (w_go) begin
                r_ph <= n_ph; r_acc <= n_acc; r_left <= n_left; r_pos <= n_pos;
                r_typ <= n_typ; r_flg <= n_flg; r_pay <= n_pay; r_rng <= n_rng;
                r_sav <= n_sav; r_disc <= n_disc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) r_out <= n_out;
    end

    `QFP_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `QFP_ASSERT_IMP(a_err_notdone, i_clk, i_rst_n,
        o_valid && o_data.item_kind == qfp_pkg::K_ERR, !o_data.frame_done)
    `QFP_ASSERT_IMP(a_disc_idle, i_clk, i_rst_n, r_disc, r_ph == qfp_pkg::PH_TYPE)
endmodule
`default_nettype wire

/* sv/quic_frame_parser.sv */
//------------------------------------------------------------------------------
// quic_frame_parser
// RFC 9000 frame parser, one decrypted payload byte a cycle unless stalled.
//------------------------------------------------------------------------------
// Usage:
//  Input channel i_in_*: one payload byte per transaction with a packet-end
//  mark on the last byte. Output channel o_out_*: zero or one decoded item
//  per input byte (varint field, payload byte, frame end, or error).
//  Config channel i_cfg_*: index 0 min CID length, index 1 max CID length.
//  Write only while idle.
//  Throughput: one byte per cycle sustained while the receiver takes results;
//  qfp_back handles a whole byte at once, including varint accumulate.
//  After its byte is accepted, an item passes the front queue, then the
//  registered result stage.
//  Stall: when the receiver holds ready low, the result register holds, the
//  parser halts while a result waits; the queue fills before i_in_ready drops.
//  Reset (synchronous, active low): parser expects a frame type, queue is
//  empty, CID limits return to 1 and 20. After an error the rest of the
//  packet is dropped without output.
//------------------------------------------------------------------------------
`default_nettype none
module quic_frame_parser #(
    parameter int QDEPTH = qfp_pkg::QDEPTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  qfp_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output qfp_pkg::t_out  o_out_data,
    input  wire            i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire  [0:0]     i_cfg_index,
    input  wire  [7:0]     i_cfg_data
);
    logic [7:0] r_min_cid, r_max_cid;
    logic       w_q_valid, w_q_ready;
    qfp_pkg::t_cls w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cid <= 8'd1;
            r_max_cid <= 8'd20;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qfp_pkg::CFG_MIN_CID: r_min_cid <= i_cfg_data;
                qfp_pkg::CFG_MAX_CID: r_max_cid <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front stage tags each byte with the length its prefix announces.
    qfp_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_data(i_in_data),
        .i_first(1'b1),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_data(w_q_data)
    );

    qfp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_data(w_q_data),
        .i_min_cid(r_min_cid), .i_max_cid(r_max_cid),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_data(o_out_data)
    );
endmodule
`default_nettype wire

/* dv/testbench.sv */
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for quic_frame_parser. Packets are built from
// well-formed frames of every type with random content, mixed with broken
// frames, truncated packets and junk. A local model of the parser predicts
// every result item, which is compared field by field in arrival order.
// The sender works in bursts and the receiver stalls on its own pattern.
//------------------------------------------------------------------------------
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qfp_pkg::*;

    // Frame type codes (RFC 9000)
    localparam int FT_PADDING   = 0;
    localparam int FT_PING      = 1;
    localparam int FT_ACK       = 2;
    localparam int FT_ACK_ECN   = 3;
    localparam int FT_RESET     = 4;
    localparam int FT_STOP      = 5;
    localparam int FT_CRYPTO    = 6;
    localparam int FT_TOKEN     = 7;
    localparam int FT_MAX_DATA  = 16;
    localparam int FT_MAX_SDATA = 17;
    localparam int FT_MAX_SBIDI = 18;
    localparam int FT_MAX_SUNI  = 19;
    localparam int FT_DATA_BLK  = 20;
    localparam int FT_SDATA_BLK = 21;
    localparam int FT_SBLK_BIDI = 22;
    localparam int FT_SBLK_UNI  = 23;
    localparam int FT_RETIRE    = 25;
    localparam int FT_CHALLENGE = 26;
    localparam int FT_RESPONSE  = 27;
    localparam int FT_CLOSE_APP = 29;
    localparam int FT_HS_DONE   = 30;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;   // result latency plus margin

    // What a decoded field does to the parse
    typedef enum {A_VAR, A_BYTES, A_DONE, A_TOEND, A_CIDLEN, A_ERR} field_act_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_data = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_ready, out_valid, cfg_ready;
    t_out        out_data;

    quic_frame_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    //--------------------------------------------------------------------------
    // Parser model state
    //--------------------------------------------------------------------------
    t_phase      ph;
    logic [61:0] accum;
    logic [2:0]  vleft;
    logic [3:0]  fpos;
    logic [4:0]  ctype;
    logic [2:0]  cflags;
    logic [61:0] pcnt;
    logic [62:0] rcnt;
    logic [61:0] saved;
    logic [7:0]  cid_len_seen;
    logic        discard;
    logic [7:0]  min_cid, max_cid;

    t_out        expected_items[$];
    int          errors = 0;
    int          bytes_sent = 0;
    logic [7:0]  pkt[$];

    function automatic t_out mk_item(logic [1:0] kind, logic [3:0] idx, logic [61:0] val,
                                     logic done, logic [1:0] err);
        t_out r;
        r.frame_type  = ctype;
        r.type_flags  = cflags;
        r.item_kind   = kind;
        r.field_index = idx;
        r.field_value = val;
        r.frame_done  = done;
        r.error_code  = err;
        return r;
    endfunction

    function automatic void to_idle();
        ph    = PH_TYPE;
        vleft = '0;
        fpos  = '0;
    endfunction

    function automatic void model_reset();
        min_cid = 8'd1;
        max_cid = 8'd20;
        accum = '0; ctype = '0; cflags = '0; pcnt = '0; rcnt = '0;
        saved = '0; cid_len_seen = '0; discard = 1'b0;
        to_idle();
    endfunction

    // Error item; the rest of the packet is dropped
    function automatic t_out fail_item(logic [1:0] code, logic [61:0] val);
        t_out r;
        r = mk_item(K_ERR, fpos, val, 1'b0, code);
        to_idle();
        discard = 1'b1;
        return r;
    endfunction

    function automatic bit on_type(logic [61:0] v, output t_out r);
        if (v > 62'd30) begin
            r = fail_item(E_FRAME, v);
            return 1;
        end
        ctype  = v[4:0];
        cflags = '0;
        if (v == FT_PADDING || v == FT_PING || v == FT_HS_DONE) begin
            r = mk_item(K_DONE, 4'd0, '0, 1'b1, E_NONE);
            to_idle();
            return 1;
        end
        if (v >= 8 && v <= 15) begin
            ctype  = T_STREAM;
            cflags = v[2:0];
        end else if (v == T_CLOSE || v == FT_CLOSE_APP) begin
            ctype  = T_CLOSE;
            cflags = {2'b00, v[0]};
        end
        fpos = '0;
        if (v == FT_CHALLENGE || v == FT_RESPONSE) begin
            ph   = PH_BYTES;
            pcnt = 62'd8;
        end else begin
            ph = PH_VAR;
        end
        return 0;
    endfunction

    function automatic bit on_field(logic [61:0] v, logic pe, output t_out r);
        int          p;
        int          np;
        logic [1:0]  code;
        logic [61:0] cnt;
        field_act_t  act;
        p = fpos; np = 0; code = E_FRAME; cnt = '0; act = A_DONE;
        case (ctype)
            FT_ACK, FT_ACK_ECN: begin
                if (p == 0) begin act = A_VAR; np = 1; end
                else if (p == 1) begin act = A_VAR; np = 2; end
                else if (p == 2) begin rcnt = {v, 1'b1}; act = A_VAR; np = 3; end
                else if (p <= 5) begin
                    rcnt = rcnt - 63'd1;
                    if (rcnt == 0) begin
                        if (ctype == FT_ACK_ECN) begin act = A_VAR; np = 6; end
                    end else begin
                        act = A_VAR; np = (p == 4) ? 5 : 4;
                    end
                end else if (p < 8) begin act = A_VAR; np = p + 1; end
            end
            FT_RESET: if (p < 2) begin act = A_VAR; np = p + 1; end
            FT_STOP, FT_MAX_SDATA, FT_SDATA_BLK: if (p < 1) begin act = A_VAR; np = 1; end
            FT_CRYPTO: begin
                if (p == 0) begin saved = v; act = A_VAR; np = 1; end
                else if ({1'b0, saved} + {1'b0, v} > {1'b0, VMAX}) act = A_ERR;
                else if (v != 0) begin act = A_BYTES; np = 2; cnt = v; end
            end
            FT_TOKEN: begin
                if (v == 0) act = A_ERR;
                else begin act = A_BYTES; np = 1; cnt = v; end
            end
            T_STREAM: begin
                if (p == 0 && (cflags & FL_OFF)) begin act = A_VAR; np = 1; end
                else if (p < 2 && (cflags & FL_LEN)) begin act = A_VAR; np = 2; end
                else if (p < 2) begin act = pe ? A_DONE : A_TOEND; np = 3; end
                else if (v != 0) begin act = A_BYTES; np = 3; cnt = v; end
            end
            FT_MAX_SBIDI, FT_MAX_SUNI: if (v > LIM60) act = A_ERR;
            FT_SBLK_BIDI, FT_SBLK_UNI: if (v > LIM60) begin act = A_ERR; code = E_LIMIT; end
            T_NEWCID: begin
                if (p == 0) begin saved = v; act = A_VAR; np = 1; end
                else if (v > saved) act = A_ERR;
                else begin act = A_CIDLEN; np = 2; end
            end
            T_CLOSE: begin
                if (p == 0) begin act = A_VAR; np = cflags[0] ? 2 : 1; end
                else if (p == 1) begin act = A_VAR; np = 2; end
                else if (v != 0) begin act = A_BYTES; np = 3; cnt = v; end
            end
            default: ;
        endcase
        if (act == A_ERR) begin
            r = fail_item(code, '0);
            return 1;
        end
        r = mk_item(K_FIELD, p[3:0], v, act == A_DONE, E_NONE);
        if (act == A_DONE) begin
            to_idle();
            return 1;
        end
        fpos  = np[3:0];
        vleft = '0;
        case (act)
            A_VAR:   ph = PH_VAR;
            A_BYTES: begin ph = PH_BYTES; pcnt = cnt; end
            A_TOEND: ph = PH_TOEND;
            default: ph = PH_CIDLEN;
        endcase
        return 1;
    endfunction

    // One accepted byte; returns 1 when it yields a result item
    function automatic bit predict_byte(logic [7:0] b, logic pe, output t_out r);
        bit have;
        have = 0;
        r = '0;
        if (discard) begin
            if (pe) begin
                discard = 1'b0;
                to_idle();
            end
            return 0;
        end
        case (ph)
            PH_TYPE, PH_VAR: begin
                if (vleft == 0) begin
                    if (ph == PH_TYPE) begin
                        ctype = '0; cflags = '0; fpos = '0;
                    end
                    accum = {56'd0, b[5:0]};
                    case (b[7:6])
                        2'd0: vleft = 3'd0;
                        2'd1: vleft = 3'd1;
                        2'd2: vleft = 3'd3;
                        default: vleft = 3'd7;
                    endcase
                end else begin
                    accum = {accum[53:0], b};
                    vleft = vleft - 3'd1;
                end
                if (vleft == 0)
                    have = (ph == PH_TYPE) ? on_type(accum, r) : on_field(accum, pe, r);
            end
            PH_BYTES: begin
                pcnt = pcnt - 62'd1;
                if (pcnt == 0 && ctype == T_NEWCID && fpos == 4'd3) begin
                    r = mk_item(K_BYTE, fpos, {54'd0, b}, 1'b0, E_NONE);
                    fpos = 4'd4;
                    pcnt = 62'd16;
                end else if (pcnt == 0) begin
                    r = mk_item(K_BYTE, fpos, {54'd0, b}, 1'b1, E_NONE);
                    to_idle();
                end else begin
                    r = mk_item(K_BYTE, fpos, {54'd0, b}, 1'b0, E_NONE);
                end
                have = 1;
            end
            PH_TOEND: begin
                r = mk_item(K_BYTE, fpos, {54'd0, b}, pe, E_NONE);
                if (pe) to_idle();
                have = 1;
            end
            default: begin
                // connection ID length byte
                if (b < min_cid || b > max_cid) begin
                    r = fail_item(E_FRAME, '0);
                end else begin
                    cid_len_seen = b;
                    r = mk_item(K_FIELD, 4'd2, {54'd0, b}, 1'b0, E_NONE);
                    ph = PH_BYTES;
                    if (b == 0) begin fpos = 4'd4; pcnt = 62'd16; end
                    else begin fpos = 4'd3; pcnt = {54'd0, b}; end
                end
                have = 1;
            end
        endcase
        if (pe) begin
            // truncated frame: error replaces any field item
            if (!(have && r.item_kind == K_ERR) && !(ph == PH_TYPE && vleft == 0)) begin
                r = mk_item(K_ERR, fpos, '0, 1'b0, E_FRAME);
                have = 1;
            end
            discard = 1'b0;
            to_idle();
        end
        return have;
    endfunction

    //--------------------------------------------------------------------------
    // Packet building
    //--------------------------------------------------------------------------
    function automatic void put_var(logic [61:0] v);
        logic [63:0] w;
        int          code;
        int          len;
        if (v < 62'd64) code = 0;
        else if (v < 62'd16384) code = 1;
        else if (v < 62'h4000_0000) code = 2;
        else code = 3;
        if (code < 3 && $urandom_range(0, 3) == 0) code++;   // non-minimal encoding
        len = 1 << code;
        w = {2'b00, v};
        w[8*len-1 -: 2] = code[1:0];
        for (int i = 0; i < len; i++) pkt.push_back(w[8*(len-1-i) +: 8]);
    endfunction

    function automatic logic [61:0] rand_val();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return w[5:0];
            1: return w[13:0];
            2: return w[29:0];
            default: return w[61:0];
        endcase
    endfunction

    function automatic void put_bytes(int n);
        repeat (n) pkt.push_back($urandom_range(0, 255));
    endfunction

    // Appends one frame; to_end is set when its data runs to packet end
    function automatic void gen_frame(int t, bit fault, output bit to_end);
        int          n;
        logic [61:0] v;
        to_end = 0;
        put_var(t);
        case (t)
            FT_ACK, FT_ACK_ECN: begin
                n = $urandom_range(0, 2);
                put_var(rand_val()); put_var(rand_val()); put_var(n); put_var(rand_val());
                repeat (2 * n) put_var(rand_val());
                if (t == FT_ACK_ECN) repeat (3) put_var(rand_val());
            end
            FT_RESET: repeat (3) put_var(rand_val());
            FT_STOP, FT_MAX_SDATA, FT_SDATA_BLK: repeat (2) put_var(rand_val());
            FT_CRYPTO: begin
                n = $urandom_range(0, 6);
                if (fault) begin
                    put_var(VMAX - $urandom_range(0, 3));
                    n = $urandom_range(4, 6);
                end else begin
                    put_var(rand_val() >> 1);
                end
                put_var(n);
                put_bytes(n);
            end
            FT_TOKEN: begin
                n = fault ? 0 : $urandom_range(1, 6);
                put_var(n);
                put_bytes(n);
            end
            8, 9, 10, 11, 12, 13, 14, 15: begin
                n = $urandom_range(0, 6);
                put_var(rand_val());
                if (t & FL_OFF) put_var(rand_val());
                if (t & FL_LEN) put_var(n);
                else to_end = 1;
                put_bytes(n);
            end
            FT_MAX_SBIDI, FT_MAX_SUNI, FT_SBLK_BIDI, FT_SBLK_UNI: begin
                v = rand_val();
                if (fault) v = LIM60 + $urandom_range(1, 3);
                else if (v > LIM60) v = ($urandom_range(0, 1) != 0) ? LIM60 : v[59:0];
                put_var(v);
            end
            FT_MAX_DATA, FT_DATA_BLK, FT_RETIRE: put_var(rand_val());
            T_NEWCID: begin
                v = rand_val() >> 1;
                put_var(v);
                if (fault && $urandom_range(0, 1) != 0) begin
                    put_var(v + 62'd1);
                end else begin
                    put_var(v >> $urandom_range(0, 8));
                    if (min_cid > max_cid) n = $urandom_range(0, 255);
                    else if (fault && min_cid > 0) n = $urandom_range(0, min_cid - 1);
                    else if (fault && max_cid < 255) n = $urandom_range(max_cid + 1, 255);
                    else n = min_cid + $urandom_range(0, (max_cid - min_cid > 8) ? 8
                                                        : max_cid - min_cid);
                    pkt.push_back(n[7:0]);
                    put_bytes(n + 16);
                end
            end
            FT_CHALLENGE, FT_RESPONSE: put_bytes(8);
            T_CLOSE, FT_CLOSE_APP: begin
                n = $urandom_range(0, 6);
                put_var(rand_val());
                if (t == T_CLOSE) put_var(rand_val());
                put_var(n);
                put_bytes(n);
            end
            default: ;
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // Sender: bursts of transactions with random gaps
    //--------------------------------------------------------------------------
    int burst_left = 0;
    bit no_gaps = 0;

    task automatic send_byte(logic [7:0] b, logic pe);
        int   gap;
        t_out r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, packet_end: pe};
        do @(posedge i_clk); while (!in_ready);
        bytes_sent++;
        if (predict_byte(b, pe, r)) expected_items.push_back(r);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    // Quiesce: let every expected result come out, then allow for latency
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == CFG_MIN_CID) min_cid = val;
        else max_cid = val;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One packet of random frames, some faulty or truncated, or noise
    task automatic rand_packet();
        bit to_end;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            put_bytes($urandom_range(1, 8));
        end else if (sel == 1) begin
            put_var(31 + $urandom_range(0, 1000));
            put_bytes($urandom_range(0, 3));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                gen_frame($urandom_range(0, 30), $urandom_range(0, 11) == 0, to_end);
                if (to_end) break;
            end
            if (pkt.size() > 1 && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
        end
        send_packet();
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------
    task automatic test_frame_types();
        bit to_end;
        for (int t = 0; t <= 30; t++) begin
            gen_frame(t, 0, to_end);
            send_packet();
        end
    endtask

    task automatic test_field_errors();
        bit to_end;
        int bad[6] = '{FT_CRYPTO, FT_TOKEN, FT_MAX_SBIDI, FT_SBLK_UNI, T_NEWCID, T_NEWCID};
        foreach (bad[i]) begin
            gen_frame(bad[i], 1, to_end);
            gen_frame(FT_PING, 0, to_end);   // dropped after the error
            send_packet();
        end
        put_var(31); send_packet();                    // smallest unknown type
        put_var(VMAX); pkt.push_back(8'h01); send_packet();
        gen_frame(FT_CRYPTO, 0, to_end);               // truncated frame
        void'(pkt.pop_back());
        send_packet();
        put_var(8); put_var(rand_val()); send_packet();  // STREAM ending on its id
        put_var(62'd1); put_var(62'd0); pkt.push_back(8'hFF); send_packet();
    endtask

    task automatic test_cid_limits();
        logic [7:0] lims[4][2] = '{'{8'd0, 8'd255}, '{8'd255, 8'd0},
                                   '{8'd8, 8'd8}, '{8'd1, 8'd20}};
        bit to_end;
        foreach (lims[i]) begin
            drain();
            write_cfg(CFG_MIN_CID, lims[i][0]);
            write_cfg(CFG_MAX_CID, lims[i][1]);
            repeat (12) begin
                gen_frame(T_NEWCID, $urandom_range(0, 2) == 0, to_end);
                send_packet();
            end
            repeat (10) rand_packet();
        end
    endtask

    task automatic test_random_traffic();
        bit paused;
        paused = 0;
        while (bytes_sent < 650 + 1000) begin
            if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
            if (!paused && bytes_sent > 1000) begin
                drain();   // pause until every result has drained
                paused = 1;
            end
            rand_packet();
        end
    endtask

    //--------------------------------------------------------------------------
    // Receiver stall pattern: free flow, light random stalls, long stall runs
    //--------------------------------------------------------------------------
    int cycle = 0;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        case ((cycle / 300) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 2) != 0);
            default: out_ready <= ((cycle % 16) < 5);
        endcase
    end

    //--------------------------------------------------------------------------
    // Result checker: every accepted transaction against the oldest expectation
    //--------------------------------------------------------------------------
    task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_items.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                errors++;
            end else begin
                e = expected_items.pop_front();
                cmp_field("frame_type",  e.frame_type,  out_data.frame_type);
                cmp_field("type_flags",  e.type_flags,  out_data.type_flags);
                cmp_field("item_kind",   e.item_kind,   out_data.item_kind);
                cmp_field("field_index", e.field_index, out_data.field_index);
                cmp_field("field_value", e.field_value, out_data.field_value);
                cmp_field("frame_done",  e.frame_done,  out_data.frame_done);
                cmp_field("error_code",  e.error_code,  out_data.error_code);
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_frame_types();
        test_field_errors();
        test_cid_limits();
        test_random_traffic();
        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_items.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+sv
sv/qfp_pkg.sv
sv/qfp_front.sv
sv/qfp_back.sv
sv/quic_frame_parser.sv
dv/testbench.sv
